[rtl/core/tdc_tof_pkg.sv]
// ----------------------------------------------------------------------------
// tdc_tof_pkg
// Shared types and constants of the converter time-of-flight pipeline.
// ----------------------------------------------------------------------------
package tdc_tof_pkg;

   localparam int FRAC_BITS_DEF = 20;

   localparam int CNT_W    = 24;
   localparam int PER_W    = 20;
   localparam int CALP_W   = 6;
   localparam int CPS_W    = CNT_W + PER_W;
   localparam int TOF_W    = 48;
   localparam int CSR_AW   = 3;
   localparam int CSR_DW   = 32;

   localparam logic [PER_W-1:0]  PER_RESET  = 20'd125000;
   localparam logic [CALP_W-1:0] CALP_RESET = 6'd10;
   localparam logic [TOF_W-1:0]  TOF_MAX    = {TOF_W{1'b1}};

   typedef enum logic [1:0] {
      ST_OK          = 2'd0,
      ST_CAL_INVALID = 2'd1,
      ST_NEG_CLAMP   = 2'd2,
      ST_SATURATED   = 2'd3
   } status_type;

   typedef enum logic [0:0] {
      REG_CLOCK_PERIOD = 1'b0,
      REG_CAL_PERIODS  = 1'b1
   } reg_index_type;

   // per-request values that ride along the dividers
   typedef struct packed {
      logic             invalid;
      logic             neg;
      logic [CNT_W-1:0] mag;
      logic [CPS_W-1:0] coarse_ps;
   } meas_type;

endpackage

[rtl/core/tdc_tof_front.sv]
// ----------------------------------------------------------------------------
// tdc_tof_front
// Entry stage: calibration difference, fine-time magnitude, coarse time.
// ----------------------------------------------------------------------------
module tdc_tof_front (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                en,
   input  logic                                in_valid,
   input  logic [tdc_tof_pkg::CNT_W-1:0]       cal_first,
   input  logic [tdc_tof_pkg::CNT_W-1:0]       cal_second,
   input  logic [tdc_tof_pkg::CNT_W-1:0]       fine_start,
   input  logic [tdc_tof_pkg::CNT_W-1:0]       fine_stop,
   input  logic [tdc_tof_pkg::CNT_W-1:0]       coarse_clocks,
   input  logic [tdc_tof_pkg::PER_W-1:0]       clock_period_ps,
   input  logic [tdc_tof_pkg::CALP_W-1:0]      cal_periods,
   output logic                                out_valid,
   output logic [tdc_tof_pkg::CNT_W-1:0]       out_diff,
   output logic [tdc_tof_pkg::CALP_W-1:0]      out_divisor,
   output tdc_tof_pkg::meas_type               out_meas
);

   logic                             valid_ff;
   logic [tdc_tof_pkg::CNT_W-1:0]    diff_ff, diff_in;
   logic [tdc_tof_pkg::CALP_W-1:0]   divisor_ff, divisor_in;
   tdc_tof_pkg::meas_type            meas_ff, meas_in;

   always_comb begin
      diff_in    = cal_second - cal_first;
      // periods below two act as two
      divisor_in = (cal_periods < 6'd2) ? 6'd1 : cal_periods - 6'd1;
      meas_in.invalid   = (cal_second <= cal_first);
      meas_in.neg       = (fine_start < fine_stop);
      meas_in.mag       = meas_in.neg ? fine_stop - fine_start : fine_start - fine_stop;
      meas_in.coarse_ps = tdc_tof_pkg::CPS_W'(coarse_clocks) *
                          tdc_tof_pkg::CPS_W'(clock_period_ps);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (en) begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         diff_ff    <= diff_in;
         divisor_ff <= divisor_in;
         meas_ff    <= meas_in;
      end
   end

   assign out_valid   = valid_ff;
   assign out_diff    = diff_ff;
   assign out_divisor = divisor_ff;
   assign out_meas    = meas_ff;

endmodule

[rtl/core/tdc_tof_div.sv]
// ----------------------------------------------------------------------------
// tdc_tof_div
// Pipelined restoring divider, STEP_N quotient bits per stage.
// ----------------------------------------------------------------------------
module tdc_tof_div #(
   parameter int NUM_W  = 44,
   parameter int DEN_W  = 6,
   parameter int STEP_N = 8,
   parameter int SIDE_W = 8
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              en,
   input  logic              in_valid,
   input  logic [NUM_W-1:0]  in_num,
   input  logic [DEN_W-1:0]  in_den,
   input  logic [SIDE_W-1:0] in_side,
   output logic              out_valid,
   output logic [NUM_W-1:0]  out_quo,
   output logic [SIDE_W-1:0] out_side
);

   localparam int STAGES = (NUM_W + STEP_N - 1) / STEP_N;

   logic              valid_ff [STAGES];
   logic [NUM_W-1:0]  nq_ff    [STAGES];
   logic [DEN_W-1:0]  rem_ff   [STAGES];
   logic [DEN_W-1:0]  den_ff   [STAGES];
   logic [SIDE_W-1:0] side_ff  [STAGES];

   for (genvar s = 0; s < STAGES; s++) begin : g_stage
      logic              prev_valid;
      logic [NUM_W-1:0]  prev_nq;
      logic [DEN_W-1:0]  prev_rem;
      logic [DEN_W-1:0]  prev_den;
      logic [SIDE_W-1:0] prev_side;
      logic [NUM_W-1:0]  nq_in;
      logic [DEN_W-1:0]  rem_in;

      if (s == 0) begin : g_first
         assign prev_valid = in_valid;
         assign prev_nq    = in_num;
         assign prev_rem   = '0;
         assign prev_den   = in_den;
         assign prev_side  = in_side;
      end else begin : g_next
         assign prev_valid = valid_ff[s-1];
         assign prev_nq    = nq_ff[s-1];
         assign prev_rem   = rem_ff[s-1];
         assign prev_den   = den_ff[s-1];
         assign prev_side  = side_ff[s-1];
      end

      // the numerator shifts out at the top while quotient bits fill the bottom
      always_comb begin
         logic [DEN_W:0] trial;
         nq_in  = prev_nq;
         rem_in = prev_rem;
         for (int k = 0; k < STEP_N; k++) begin
            if (s * STEP_N + k < NUM_W) begin
               trial = {rem_in, nq_in[NUM_W-1]};
               nq_in = {nq_in[NUM_W-2:0], 1'b0};
               if (trial >= {1'b0, prev_den}) begin
                  trial    = trial - {1'b0, prev_den};
                  nq_in[0] = 1'b1;
               end
               rem_in = trial[DEN_W-1:0];
            end
         end
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            valid_ff[s] <= 1'b0;
         end else if (en) begin
            valid_ff[s] <= prev_valid;
         end
      end

      always_ff @(posedge clock) begin
         if (en) begin
            nq_ff[s]   <= nq_in;
            rem_ff[s]  <= rem_in;
            den_ff[s]  <= prev_den;
            side_ff[s] <= prev_side;
         end
      end
   end

   assign out_valid = valid_ff[STAGES-1];
   assign out_quo   = nq_ff[STAGES-1];
   assign out_side  = side_ff[STAGES-1];

endmodule

[rtl/core/tdc_tof_mult.sv]
// ----------------------------------------------------------------------------
// tdc_tof_mult
// Fine-time scaling by partial products, rounding, clamping and saturation.
// ----------------------------------------------------------------------------
module tdc_tof_mult #(
   parameter int FRAC_BITS = tdc_tof_pkg::FRAC_BITS_DEF
) (
   input  logic                                                clock,
   input  logic                                                reset,
   input  logic                                                en,
   input  logic                                                in_valid,
   input  logic [tdc_tof_pkg::PER_W+2*FRAC_BITS-1:0]           in_norm,
   input  tdc_tof_pkg::meas_type                               in_meas,
   output logic                                                out_valid,
   output logic [tdc_tof_pkg::TOF_W-1:0]                       out_tof,
   output tdc_tof_pkg::status_type                             out_status
);

   localparam int CW     = tdc_tof_pkg::CNT_W;
   localparam int NORM_W = tdc_tof_pkg::PER_W + 2 * FRAC_BITS;
   localparam int NCH    = (NORM_W + CW - 1) / CW;
   localparam int PAD_W  = NCH * CW;
   localparam int PROD_W = NORM_W + CW;
   localparam int SH_W   = PROD_W - FRAC_BITS;

   logic [PAD_W-1:0]       norm_pad;
   logic                   v1_ff, v2_ff, v3_ff;
   logic [2*CW-1:0]        pp_ff [NCH];
   tdc_tof_pkg::meas_type  m1_ff, m2_ff;
   logic [PROD_W-1:0]      prod_ff, prod_in;
   logic [tdc_tof_pkg::TOF_W-1:0] tof_ff, tof_in;
   tdc_tof_pkg::status_type       status_ff, status_in;

   assign norm_pad = PAD_W'(in_norm);

   always_comb begin
      prod_in = '0;
      for (int i = 0; i < NCH; i++) begin
         prod_in = prod_in + (PROD_W'(pp_ff[i]) << (CW * i));
      end
   end

   always_comb begin
      logic [SH_W:0] sh;
      logic [SH_W:0] cps;
      logic [SH_W:0] rnd;
      logic [SH_W:0] total;
      logic [SH_W:0] diff;
      sh    = (SH_W+1)'(prod_ff[PROD_W-1:FRAC_BITS]);
      cps   = (SH_W+1)'(m2_ff.coarse_ps);
      // floor of a negative value: round the magnitude up
      rnd   = sh + (SH_W+1)'(m2_ff.neg & (|prod_ff[FRAC_BITS-1:0]));
      total = sh + cps;
      diff  = cps - rnd;
      if (m2_ff.invalid) begin
         tof_in    = '0;
         status_in = tdc_tof_pkg::ST_CAL_INVALID;
      end else if (m2_ff.neg) begin
         if (rnd > cps) begin
            tof_in    = '0;
            status_in = tdc_tof_pkg::ST_NEG_CLAMP;
         end else begin
            tof_in    = diff[tdc_tof_pkg::TOF_W-1:0];
            status_in = tdc_tof_pkg::ST_OK;
         end
      end else if (total > (SH_W+1)'(tdc_tof_pkg::TOF_MAX)) begin
         tof_in    = tdc_tof_pkg::TOF_MAX;
         status_in = tdc_tof_pkg::ST_SATURATED;
      end else begin
         tof_in    = total[tdc_tof_pkg::TOF_W-1:0];
         status_in = tdc_tof_pkg::ST_OK;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
      end else if (en) begin
         v1_ff <= in_valid;
         v2_ff <= v1_ff;
         v3_ff <= v2_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         for (int i = 0; i < NCH; i++) begin
            pp_ff[i] <= norm_pad[i*CW +: CW] * in_meas.mag;
         end
         m1_ff     <= in_meas;
         prod_ff   <= prod_in;
         m2_ff     <= m1_ff;
         tof_ff    <= tof_in;
         status_ff <= status_in;
      end
   end

   assign out_valid  = v3_ff;
   assign out_tof    = tof_ff;
   assign out_status = status_ff;

endmodule

[rtl/core/tdc_time_of_flight_calc_core.sv]
// ----------------------------------------------------------------------------
// tdc_time_of_flight_calc_core
// Calibrated time of flight from one converter readout per request.
// ----------------------------------------------------------------------------
// Usage:
//   req_* carries one readout per request; rsp_* returns one result for each,
//   in order. csr_* is an APB-style port holding clock_period_ps (0x0) and
//   cal_periods (0x4); write it only while the pipeline is empty.
// Throughput: one request per cycle while no result waits on rsp_tready.
// Pipeline: the front stage, the calibration divider, the normalized-LSB
//   divider and the scaling multiply, in that order. The LSB divider is the
//   longest: one quotient bit of a (20+2*FRAC_BITS)-bit quotient per stage.
//   The calibration divider takes eight bits per stage; the scaling
//   multiply is split into 24-bit partial products.
// Reset: empties the pipeline and loads 125000 ps and 10 periods.
// Stall: when rsp_tready is low and a result waits, the whole pipeline holds
//   and req_tready drops; nothing is lost or repeated.
// ----------------------------------------------------------------------------
module tdc_time_of_flight_calc_core #(
   parameter int FRAC_BITS = tdc_tof_pkg::FRAC_BITS_DEF
) (
   input  logic          clock,
   input  logic          reset,
   input  logic          req_tvalid,
   output logic          req_tready,
   // cal_first, cal_second, fine_start, fine_stop, coarse_clocks
   input  logic [119:0]  req_tdata,
   output logic          rsp_tvalid,
   input  logic          rsp_tready,
   // tof_ps
   output logic [47:0]   rsp_tdata,
   // status
   output logic [1:0]    rsp_tuser,
   input  logic                              csr_psel,
   input  logic                              csr_penable,
   input  logic                              csr_pwrite,
   input  logic [tdc_tof_pkg::CSR_AW-1:0]    csr_paddr,
   input  logic [tdc_tof_pkg::CSR_DW-1:0]    csr_pwdata,
   output logic [tdc_tof_pkg::CSR_DW-1:0]    csr_prdata,
   output logic                              csr_pready
);

   localparam int CW     = tdc_tof_pkg::CNT_W;
   localparam int D1_W   = CW + FRAC_BITS;
   localparam int NORM_W = tdc_tof_pkg::PER_W + 2 * FRAC_BITS;
   localparam int MEAS_W = $bits(tdc_tof_pkg::meas_type);

   logic [tdc_tof_pkg::PER_W-1:0]  per_ff;
   logic [tdc_tof_pkg::CALP_W-1:0] calp_ff;
   logic                           adv;
   logic                           csr_wr;
   tdc_tof_pkg::reg_index_type     csr_idx;

   logic                             f_valid;
   logic [CW-1:0]                    f_diff;
   logic [tdc_tof_pkg::CALP_W-1:0]   f_divisor;
   tdc_tof_pkg::meas_type            f_meas;

   logic                             d1_valid;
   logic [D1_W-1:0]                  d1_cal_count;
   logic [MEAS_W-1:0]                d1_side;
   tdc_tof_pkg::meas_type            d1_meas;

   logic                             d2_valid;
   logic [NORM_W-1:0]                d2_norm;
   logic [MEAS_W-1:0]                d2_side;
   tdc_tof_pkg::status_type          status;

   // advance the whole pipeline unless a result is waiting
   assign adv        = !rsp_tvalid || rsp_tready;
   assign req_tready = adv;

   assign csr_pready = 1'b1;
   assign csr_wr     = csr_psel && csr_penable && csr_pwrite && csr_pready;
   assign csr_idx    = tdc_tof_pkg::reg_index_type'(csr_paddr[2]);

   always_ff @(posedge clock) begin
      if (reset) begin
         per_ff  <= tdc_tof_pkg::PER_RESET;
         calp_ff <= tdc_tof_pkg::CALP_RESET;
      end else if (csr_wr) begin
         unique case (csr_idx)
            tdc_tof_pkg::REG_CLOCK_PERIOD: per_ff  <= csr_pwdata[tdc_tof_pkg::PER_W-1:0];
            tdc_tof_pkg::REG_CAL_PERIODS:  calp_ff <= csr_pwdata[tdc_tof_pkg::CALP_W-1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      unique case (csr_idx)
         tdc_tof_pkg::REG_CLOCK_PERIOD: csr_prdata = tdc_tof_pkg::CSR_DW'(per_ff);
         tdc_tof_pkg::REG_CAL_PERIODS:  csr_prdata = tdc_tof_pkg::CSR_DW'(calp_ff);
         default:                       csr_prdata = '0;
      endcase
   end

   tdc_tof_front u_front (
      .clock           (clock),
      .reset           (reset),
      .en              (adv),
      .in_valid        (req_tvalid),
      .cal_first       (req_tdata[23:0]),
      .cal_second      (req_tdata[47:24]),
      .fine_start      (req_tdata[71:48]),
      .fine_stop       (req_tdata[95:72]),
      .coarse_clocks   (req_tdata[119:96]),
      .clock_period_ps (per_ff),
      .cal_periods     (calp_ff),
      .out_valid       (f_valid),
      .out_diff        (f_diff),
      .out_divisor     (f_divisor),
      .out_meas        (f_meas)
   );

   tdc_tof_div #(
      .NUM_W  (D1_W),
      .DEN_W  (tdc_tof_pkg::CALP_W),
      .STEP_N (8),
      .SIDE_W (MEAS_W)
   ) u_cal_div (
      .clock     (clock),
      .reset     (reset),
      .en        (adv),
      .in_valid  (f_valid),
      .in_num    ({f_diff, {FRAC_BITS{1'b0}}}),
      .in_den    (f_divisor),
      .in_side   (f_meas),
      .out_valid (d1_valid),
      .out_quo   (d1_cal_count),
      .out_side  (d1_side)
   );

   // a zero calibration count marks the readout invalid as well
   always_comb begin
      d1_meas         = tdc_tof_pkg::meas_type'(d1_side);
      d1_meas.invalid = d1_meas.invalid || (d1_cal_count == '0);
   end

   // the user must keep clock_period_ps static while requests are in flight; the block does not enforce it
   tdc_tof_div #(
      .NUM_W  (NORM_W),
      .DEN_W  (D1_W),
      .STEP_N (1),
      .SIDE_W (MEAS_W)
   ) u_lsb_div (
      .clock     (clock),
      .reset     (reset),
      .en        (adv),
      .in_valid  (d1_valid),
      .in_num    ({per_ff, {(2*FRAC_BITS){1'b0}}}),
      .in_den    (d1_cal_count),
      .in_side   (d1_meas),
      .out_valid (d2_valid),
      .out_quo   (d2_norm),
      .out_side  (d2_side)
   );

   tdc_tof_mult #(
      .FRAC_BITS (FRAC_BITS)
   ) u_mult (
      .clock      (clock),
      .reset      (reset),
      .en         (adv),
      .in_valid   (d2_valid),
      .in_norm    (d2_norm),
      .in_meas    (tdc_tof_pkg::meas_type'(d2_side)),
      .out_valid  (rsp_tvalid),
      .out_tof    (rsp_tdata),
      .out_status (status)
   );

   assign rsp_tuser = status;

`ifndef SYNTHESIS
   a_invalid_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && (rsp_tuser == tdc_tof_pkg::ST_CAL_INVALID) |-> rsp_tdata == '0)
      else $error("invalid calibration with nonzero time");

   a_clamp_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && (rsp_tuser == tdc_tof_pkg::ST_NEG_CLAMP) |-> rsp_tdata == '0)
      else $error("negative clamp with nonzero time");

   a_sat_max: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && (rsp_tuser == tdc_tof_pkg::ST_SATURATED) |->
      rsp_tdata == tdc_tof_pkg::TOF_MAX)
      else $error("saturated result below maximum");

   a_reset_empty: assert property (@(posedge clock)
      $past(reset) |-> !rsp_tvalid)
      else $error("result present right after reset");
`endif

endmodule
